// ----- hdl/fopfl_pkg.sv -----
// ----------------------------------------------------------------------------
// Fixed object pool package
// Shared constants, codes and request/response types for the pool unit.
// ----------------------------------------------------------------------------
package fopfl_pkg;

   localparam int POOL_DEPTH = 256;
   localparam int ALIGNMENT  = 16;   // power of two

   localparam int ADDR_W   = 48;
   localparam int SIZE_W   = 17;
   localparam int SLOT_W   = 8;
   localparam int IDX_W    = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int LINK_W   = $clog2(POOL_DEPTH + 1);
   localparam int STRIDE_W = SIZE_W + 1;
   localparam int PROD_W   = STRIDE_W + LINK_W;
   localparam int ENTRY_W  = LINK_W + 1;

   localparam logic [SIZE_W-1:0] OBJECT_SIZE_RESET = SIZE_W'(16);

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_BAD_ADDR  = 2'd2,
      ST_NOT_ALLOC = 2'd3
   } status_type;

   typedef enum logic {
      CSR_POOL_BASE   = 1'b0,
      CSR_OBJECT_SIZE = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type            opcode;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [ADDR_W-1:0] granted_address;
      logic [SLOT_W-1:0] slot_index;
   } rsp_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] product;
   } mul_res_type;

   typedef struct packed {
      logic             done;
      logic [IDX_W-1:0] quotient;
      logic             exact;
   } div_res_type;

   // object size rounded up to the alignment, zero treated as one
   function automatic logic [STRIDE_W-1:0] stride_of(input logic [SIZE_W-1:0] size);
      logic [STRIDE_W-1:0] sz;
      sz = (size == '0) ? STRIDE_W'(1) : STRIDE_W'(size);
      return (sz + STRIDE_W'(ALIGNMENT - 1)) & ~STRIDE_W'(ALIGNMENT - 1);
   endfunction

endpackage

// ----- hdl/fixed_object_pool_free_list_unit.sv -----
// ----------------------------------------------------------------------------
// Fixed object pool free list unit
// Hands out and takes back fixed-size slots kept on a linked free list.
// ----------------------------------------------------------------------------
// One request is worked at a time; the next is taken while a finished
// response still waits on a stalled output. A get is paced by the
// bit-serial multiplier, which forms index times stride, one bit of the
// slot index per cycle; the base is then added to the product. A put first
// has the same multiplier form the pool span, then a restoring divider
// gives one bit of the slot index per cycle, then the link table is read
// and written. An empty-pool get answers without the multiplier, a put
// outside the pool answers after the span check, a misaligned put after
// the divider and a put of a free slot after the link table read. The next
// request is accepted in the cycle after a response is raised, so puts do
// not overlap. The link table resets through per-entry valid bits, so
// there is no clearing pass after reset.
module fixed_object_pool_free_list_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  fopfl_pkg::req_type               req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output fopfl_pkg::rsp_type               rsp_data,
   input  logic                             csr_write,
   input  fopfl_pkg::csr_index_type         csr_index,
   input  logic [fopfl_pkg::ADDR_W-1:0]     csr_wdata
);
   import fopfl_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_GET_MUL,
      S_PUT_SPAN,
      S_PUT_DIV,
      S_PUT_RD,
      S_PUT_ALLOC,
      S_PUT_LINK,
      S_DONE
   } state_type;

   state_type             state_ff;
   logic [ADDR_W-1:0]     base_ff;
   logic [SIZE_W-1:0]     size_ff;
   logic [LINK_W-1:0]     head_ff;
   logic [IDX_W-1:0]      tail_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [ADDR_W-1:0]     off_ff;
   logic                  borrow_ff;
   logic [POOL_DEPTH-1:0] valid_ff;
   logic                  rd_valid_ff;
   logic [IDX_W-1:0]      rd_addr_ff;
   rsp_type               res_ff;
   rsp_type               rsp_data_ff;
   logic                  rsp_valid_ff;

   logic [STRIDE_W-1:0]   stride_in;
   logic                  req_acc_in;
   logic                  head_empty_in;
   logic [ADDR_W:0]       off_full_in;
   logic                  span_bad_in;
   logic [IDX_W-1:0]      rd_addr_in;
   logic [ENTRY_W-1:0]    ram_rdata;
   logic [ENTRY_W-1:0]    entry_in;
   logic                  mul_start_in;
   logic [LINK_W-1:0]     mplier_in;
   logic                  div_start_in;
   logic                  wr_en_in;
   logic [IDX_W-1:0]      wr_addr_in;
   logic [ENTRY_W-1:0]    wr_data_in;
   mul_res_type           mul_res;
   div_res_type           div_res;

   assign stride_in     = stride_of(size_ff);
   assign req_stall     = (state_ff != S_IDLE);
   assign req_acc_in    = req_valid && !req_stall;
   assign head_empty_in = (head_ff >= LINK_W'(POOL_DEPTH));
   assign off_full_in   = {1'b0, req_data.address} - {1'b0, base_ff};
   assign span_bad_in   = borrow_ff || (off_ff[ADDR_W-1:PROD_W] != '0) ||
                          (off_ff[PROD_W-1:0] >= mul_res.product);
   assign rd_addr_in    = (state_ff == S_IDLE) ? head_ff[IDX_W-1:0] : idx_ff;
   // an entry never written reads as free, linked to the next index
   assign entry_in      = rd_valid_ff ? ram_rdata
                                      : {1'b0, LINK_W'(rd_addr_ff) + LINK_W'(1)};
   assign mul_start_in  = req_acc_in && !(req_data.opcode == OP_GET && head_empty_in);
   assign mplier_in     = (req_data.opcode == OP_GET) ? head_ff : LINK_W'(POOL_DEPTH);
   assign div_start_in  = (state_ff == S_PUT_SPAN) && mul_res.done && !span_bad_in;

   always_comb begin
      wr_en_in   = 1'b0;
      wr_addr_in = idx_ff;
      wr_data_in = '0;
      unique case (state_ff)
         S_GET_MUL: begin
            if (mul_res.done) begin
               wr_en_in   = 1'b1;
               wr_data_in = {1'b1, entry_in[LINK_W-1:0]};
            end
         end
         S_PUT_ALLOC: begin
            if (entry_in[LINK_W]) begin
               wr_en_in   = 1'b1;
               wr_data_in = {1'b0, LINK_W'(POOL_DEPTH)};
            end
         end
         S_PUT_LINK: begin
            wr_en_in   = 1'b1;
            wr_addr_in = tail_ff;
            wr_data_in = {1'b0, LINK_W'(idx_ff)};
         end
         default: begin
         end
      endcase
   end

   fopfl_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start_in),
      .mcand  (stride_in),
      .mplier (mplier_in),
      .res    (mul_res)
   );

   fopfl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_in),
      .dividend (off_ff[PROD_W-1:0]),
      .divisor  (stride_in),
      .res      (div_res)
   );

   // entry = {allocated, next link}
   fopfl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (POOL_DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en_in),
      .wr_addr (wr_addr_in),
      .wr_data (wr_data_in),
      .rd_addr (rd_addr_in),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= '0;
         size_ff      <= OBJECT_SIZE_RESET;
         head_ff      <= '0;
         tail_ff      <= IDX_W'(POOL_DEPTH - 1);
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_POOL_BASE:   base_ff <= csr_wdata;
               CSR_OBJECT_SIZE: size_ff <= csr_wdata[SIZE_W-1:0];
               default: begin
               end
            endcase
         end
         if (wr_en_in) begin
            valid_ff[wr_addr_in] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr_in];
         rd_addr_ff  <= rd_addr_in;
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_acc_in) begin
                  off_ff    <= off_full_in[ADDR_W-1:0];
                  borrow_ff <= off_full_in[ADDR_W];
                  if (req_data.opcode == OP_GET) begin
                     if (head_empty_in) begin
                        res_ff   <= '{status: ST_EMPTY, granted_address: '0,
                                      slot_index: '0};
                        state_ff <= S_DONE;
                     end else begin
                        idx_ff   <= head_ff[IDX_W-1:0];
                        state_ff <= S_GET_MUL;
                     end
                  end else begin
                     state_ff <= S_PUT_SPAN;
                  end
               end
            end
            S_GET_MUL: begin
               if (mul_res.done) begin
                  head_ff  <= entry_in[LINK_W-1:0];
                  res_ff   <= '{status: ST_OK,
                                granted_address: base_ff + ADDR_W'(mul_res.product),
                                slot_index: SLOT_W'(idx_ff)};
                  state_ff <= S_DONE;
               end
            end
            S_PUT_SPAN: begin
               if (mul_res.done) begin
                  if (span_bad_in) begin
                     res_ff   <= '{status: ST_BAD_ADDR, granted_address: '0,
                                   slot_index: '0};
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_PUT_DIV;
                  end
               end
            end
            S_PUT_DIV: begin
               if (div_res.done) begin
                  if (!div_res.exact) begin
                     res_ff   <= '{status: ST_BAD_ADDR, granted_address: '0,
                                   slot_index: '0};
                     state_ff <= S_DONE;
                  end else begin
                     idx_ff   <= div_res.quotient;
                     state_ff <= S_PUT_RD;
                  end
               end
            end
            S_PUT_RD: begin
               state_ff <= S_PUT_ALLOC;
            end
            S_PUT_ALLOC: begin
               if (!entry_in[LINK_W]) begin
                  res_ff   <= '{status: ST_NOT_ALLOC, granted_address: '0,
                                slot_index: SLOT_W'(idx_ff)};
                  state_ff <= S_DONE;
               end else if (head_empty_in) begin
                  head_ff  <= LINK_W'(idx_ff);
                  tail_ff  <= idx_ff;
                  res_ff   <= '{status: ST_OK, granted_address: '0,
                                slot_index: SLOT_W'(idx_ff)};
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_PUT_LINK;
               end
            end
            S_PUT_LINK: begin
               tail_ff  <= idx_ff;
               res_ff   <= '{status: ST_OK, granted_address: '0,
                             slot_index: SLOT_W'(idx_ff)};
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_data_ff  <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // head of the free list is never past the end marker
   assert property (@(posedge clock) disable iff (reset)
      head_ff <= LINK_W'(POOL_DEPTH))
      else $error("free list head out of range");

   // the slot popped by a get must be free
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GET_MUL && mul_res.done) |-> !entry_in[LINK_W])
      else $error("get popped an allocated slot");

   // multiplier results only land where they are consumed
   assert property (@(posedge clock) disable iff (reset)
      mul_res.done |-> (state_ff == S_GET_MUL || state_ff == S_PUT_SPAN))
      else $error("stray multiplier result");

   assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> state_ff == S_PUT_DIV)
      else $error("stray divider result");

   // appending at the tail only happens on a non-empty list
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUT_LINK) |-> !head_empty_in)
      else $error("tail link written on empty list");

endmodule

// ----- hdl/fopfl_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fopfl_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/fopfl_mul.sv -----
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Shift-and-add, one multiplier bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module fopfl_mul (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [fopfl_pkg::STRIDE_W-1:0]  mcand,
   input  logic [fopfl_pkg::LINK_W-1:0]    mplier,
   output fopfl_pkg::mul_res_type          res
);
   import fopfl_pkg::*;

   localparam int CNT_W = $clog2(LINK_W + 1);

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [PROD_W-1:0]   acc_ff;
   logic [PROD_W-1:0]   acc_in;
   logic [LINK_W-1:0]   mplier_ff;
   logic [STRIDE_W-1:0] mcand_ff;

   always_comb begin
      acc_in = {acc_ff[PROD_W-2:0], 1'b0};
      if (mplier_ff[LINK_W-1]) begin
         acc_in = acc_in + PROD_W'(mcand_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff   <= 1'b1;
            cnt_ff    <= CNT_W'(LINK_W);
            acc_ff    <= '0;
            mplier_ff <= mplier;
            mcand_ff  <= mcand;
         end else if (busy_ff) begin
            acc_ff    <= acc_in;
            mplier_ff <= mplier_ff << 1;
            cnt_ff    <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign res.done    = done_ff;
   assign res.product = acc_ff;

endmodule

// ----- hdl/fopfl_div.sv -----
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring division, one quotient bit per cycle; flags a zero remainder.
// ----------------------------------------------------------------------------
module fopfl_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [fopfl_pkg::PROD_W-1:0]    dividend,
   input  logic [fopfl_pkg::STRIDE_W-1:0]  divisor,
   output fopfl_pkg::div_res_type          res
);
   import fopfl_pkg::*;

   localparam int CNT_W = $clog2(IDX_W + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [PROD_W-1:0] rem_ff;
   logic [PROD_W-1:0] dsh_ff;
   logic [IDX_W-1:0]  q_ff;
   logic              ge_in;

   assign ge_in = (rem_ff >= dsh_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(IDX_W);
            rem_ff  <= dividend;
            dsh_ff  <= PROD_W'(divisor) << (IDX_W - 1);
            q_ff    <= '0;
         end else if (busy_ff) begin
            if (ge_in) begin
               rem_ff <= rem_ff - dsh_ff;
            end
            q_ff   <= (q_ff << 1) | IDX_W'(ge_in);
            dsh_ff <= dsh_ff >> 1;
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign res.done     = done_ff;
   assign res.quotient = q_ff;
   assign res.exact    = (rem_ff == '0);

endmodule
